>>> rtl/core/env_sensor_compensation_macros.svh
// ---------------------------------------------------------------------------
// env_sensor_compensation_macros
// Assertion shorthands shared by the compensation checker.
// ---------------------------------------------------------------------------
`ifndef ENV_SENSOR_COMPENSATION_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_MACROS_SVH

// same-cycle implication, disabled during reset
`define ESC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/esc_pkg.sv
// ---------------------------------------------------------------------------
// esc_pkg
// Types, register indexes and constants of the sensor compensation block.
// ---------------------------------------------------------------------------
package esc_pkg;

  // one frame of raw readings
  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_t;

  // one compensated result
  typedef struct packed {
    logic signed [17:0] temperature_centideg;
    logic [23:0]        pressure_pa;
    logic               pressure_invalid;
    logic [16:0]        humidity_q10;
  } out_t;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_CAL       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_CAL_LOW  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_CAL_HIGH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_CAL_NINE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HUM_CAL        = 3'd4;

  // divider geometry: 64-bit dividend magnitude, 31-bit divisor magnitude
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 31;

  // compensation constants
  localparam int TF_OFFSET_P  = 128000;
  localparam int PRESS_BASE   = 1048576;
  localparam int PRESS_SCALE  = 3125;
  localparam int TF_OFFSET_H  = 76800;
  localparam int HUM_ROUND    = 16384;
  localparam int HUM_W_BASE   = 2097152;
  localparam int HUM_H2_ROUND = 8192;
  localparam int HUM_Z_BASE   = 32768;
  localparam int HUM_MAX_Q22  = 419430400;

endpackage

>>> rtl/core/esc_div.sv
// ---------------------------------------------------------------------------
// esc_div
// Pipelined radix-2 restoring divider on magnitudes, one quotient bit per
// stage, with a side payload that travels alongside.
// ---------------------------------------------------------------------------
module esc_div #(
  parameter int N_W    = esc_pkg::DIV_NUM_W,
  parameter int D_W    = esc_pkg::DIV_DEN_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [N_W-1:0]    num,
  input  logic [D_W-1:0]    den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [N_W-1:0]    quo,
  output logic [SIDE_W-1:0] side_out
);

  logic [N_W-1:0]    nq  [N_W];
  logic [D_W-1:0]    rem [N_W];
  logic [D_W-1:0]    dd  [N_W];
  logic [SIDE_W-1:0] sd  [N_W];
  logic [N_W-1:0]    vld;

  for (genvar k = 0; k < N_W; k++) begin : g_stage
    logic [N_W-1:0]    nq_in;
    logic [D_W-1:0]    rem_in;
    logic [D_W-1:0]    den_in;
    logic [SIDE_W-1:0] side_in;
    logic              v_in;
    logic [D_W:0]      trial;
    logic [D_W:0]      diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign nq_in   = num;
      assign rem_in  = '0;
      assign den_in  = den;
      assign side_in = side;
      assign v_in    = in_valid;
    end else begin : g_rest
      assign nq_in   = nq[k-1];
      assign rem_in  = rem[k-1];
      assign den_in  = dd[k-1];
      assign side_in = sd[k-1];
      assign v_in    = vld[k-1];
    end

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_in, nq_in[N_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        nq[k]  <= {nq_in[N_W-2:0], ge};
        rem[k] <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
        dd[k]  <= den_in;
        sd[k]  <= side_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end
  end

  assign out_valid = vld[N_W-1];
  assign quo       = nq[N_W-1];
  assign side_out  = sd[N_W-1];

endmodule

>>> rtl/core/env_sensor_compensation.sv
// ---------------------------------------------------------------------------
// env_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity frames.
// ---------------------------------------------------------------------------
// Takes one frame per cycle while in_stall is low and returns one result per
// frame, in order. Each frame passes through eight stages of temperature,
// pressure set-up and humidity math, a 64-stage pipelined divider (one
// quotient bit per stage) for the pressure, five finishing stages and the
// output register. A two-entry output buffer lets the pipeline keep taking
// items while one result waits; in_stall rises only once both entries are
// full. Calibration registers reset to zero; the user must write them only
// while no item is in flight, as the block itself does not enforce it. With
// zero calibration the pressure divisor is zero, so pressure reads 0 with pressure_invalid set.
module env_sensor_compensation (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [esc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  esc_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output esc_pkg::out_t                      out_data
);

  typedef struct packed {
    logic               neg;
    logic               zero;
    logic signed [17:0] temp;
    logic signed [31:0] hw;
    logic signed [31:0] ss;
  } side_t;

  // calibration registers
  logic [47:0]        temp_cal;
  logic [63:0]        press_cal_low;
  logic [63:0]        press_cal_high;
  logic signed [15:0] press_cal_nine;
  logic [63:0]        hum_cal;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal       <= '0;
      press_cal_low  <= '0;
      press_cal_high <= '0;
      press_cal_nine <= '0;
      hum_cal        <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        esc_pkg::REG_TEMP_CAL:       temp_cal       <= cfg_data[47:0];
        esc_pkg::REG_PRESS_CAL_LOW:  press_cal_low  <= cfg_data;
        esc_pkg::REG_PRESS_CAL_HIGH: press_cal_high <= cfg_data;
        esc_pkg::REG_PRESS_CAL_NINE: press_cal_nine <= $signed(cfg_data[15:0]);
        esc_pkg::REG_HUM_CAL:        hum_cal        <= cfg_data;
        default: ;
      endcase
    end
  end

  // coefficient fields
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic [7:0]         h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = temp_cal[15:0];
  assign t2 = $signed(temp_cal[31:16]);
  assign t3 = $signed(temp_cal[47:32]);
  assign p1 = press_cal_low[15:0];
  assign p2 = $signed(press_cal_low[31:16]);
  assign p3 = $signed(press_cal_low[47:32]);
  assign p4 = $signed(press_cal_low[63:48]);
  assign p5 = $signed(press_cal_high[15:0]);
  assign p6 = $signed(press_cal_high[31:16]);
  assign p7 = $signed(press_cal_high[47:32]);
  assign p8 = $signed(press_cal_high[63:48]);
  assign p9 = press_cal_nine;
  assign h1 = hum_cal[7:0];
  assign h2 = $signed(hum_cal[23:8]);
  assign h3 = hum_cal[31:24];
  assign h4 = $signed(hum_cal[43:32]);
  assign h5 = $signed(hum_cal[55:44]);
  assign h6 = $signed(hum_cal[63:56]);

  // pipeline advance: stops only when the output buffer is full
  logic en;
  logic skid_full;
  assign en       = !skid_full;
  assign in_stall = skid_full;

  logic [7:0] fv;   // front stage valid bits
  logic [3:0] bv;   // back stage valid bits
  logic       fin_valid;

  // stage 1: temperature differences and first products
  logic signed [17:0] a_c;
  logic signed [16:0] b_c;
  logic signed [33:0] s1_at2, s1_bb;
  logic [19:0]        s1_rp;
  logic [15:0]        s1_rh;

  assign a_c = $signed({1'b0, in_data.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign b_c = $signed({1'b0, in_data.raw_temperature[19:4]}) - $signed({1'b0, t1});

  always_ff @(posedge clk) begin
    if (en) begin
      s1_at2 <= 34'(a_c) * 34'(t2);
      s1_bb  <= 34'(b_c) * 34'(b_c);
      s1_rp  <= in_data.raw_pressure;
      s1_rh  <= in_data.raw_humidity;
    end
  end

  // stage 2: scale and third coefficient
  logic signed [21:0] bbs_c;
  logic signed [22:0] s2_x;
  logic signed [37:0] s2_bbt3;
  logic [19:0]        s2_rp;
  logic [15:0]        s2_rh;

  assign bbs_c = 22'(s1_bb >>> 12);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x    <= 23'(s1_at2 >>> 11);
      s2_bbt3 <= 38'(bbs_c) * 38'(t3);
      s2_rp   <= s1_rp;
      s2_rh   <= s1_rh;
    end
  end

  // stage 3: fine temperature
  logic signed [23:0] s3_tf;
  logic [19:0]        s3_rp;
  logic [15:0]        s3_rh;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_tf <= 24'(s2_x) + 24'(s2_bbt3 >>> 14);
      s3_rp <= s2_rp;
      s3_rh <= s2_rh;
    end
  end

  // stage 4: temperature result, pressure and humidity first products
  logic signed [26:0] t5_c;
  logic signed [24:0] v1_c;
  logic signed [31:0] vh_c;
  logic signed [17:0] s4_temp;
  logic signed [47:0] s4_sq;
  logic signed [40:0] s4_v1p5, s4_v1p2;
  logic signed [31:0] s4_h5v, s4_hy, s4_hz;
  logic [19:0]        s4_rp;
  logic [15:0]        s4_rh;

  assign t5_c = 27'(s3_tf) * 27'(5) + 27'(128);
  assign v1_c = 25'(s3_tf) - 25'(esc_pkg::TF_OFFSET_P);
  assign vh_c = 32'(s3_tf) - 32'(esc_pkg::TF_OFFSET_H);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_temp <= 18'(t5_c >>> 8);
      s4_sq   <= 48'(v1_c) * 48'(v1_c);
      s4_v1p5 <= 41'(v1_c) * 41'(p5);
      s4_v1p2 <= 41'(v1_c) * 41'(p2);
      s4_h5v  <= 32'(h5) * vh_c;
      s4_hy   <= vh_c * 32'(h6);
      s4_hz   <= vh_c * $signed(32'(h3));
      s4_rp   <= s3_rp;
      s4_rh   <= s3_rh;
    end
  end

  // stage 5: squared terms, humidity x, y and z
  logic signed [31:0] xs_c;
  logic signed [63:0] s5_sq6, s5_sq3;
  logic signed [40:0] s5_v1p5, s5_v1p2;
  logic signed [17:0] s5_temp;
  logic signed [31:0] s5_x, s5_y, s5_z;
  logic [19:0]        s5_rp;

  assign xs_c = $signed({2'b00, s4_rh, 14'b0}) - $signed({h4, 20'b0}) - s4_h5v
              + 32'(esc_pkg::HUM_ROUND);

  always_ff @(posedge clk) begin
    if (en) begin
      s5_sq6  <= 64'(s4_sq) * 64'(p6);
      s5_sq3  <= 64'(s4_sq) * 64'(p3);
      s5_v1p5 <= s4_v1p5;
      s5_v1p2 <= s4_v1p2;
      s5_temp <= s4_temp;
      s5_x    <= xs_c >>> 15;
      s5_y    <= s4_hy >>> 10;
      s5_z    <= (s4_hz >>> 11) + 32'(esc_pkg::HUM_Z_BASE);
      s5_rp   <= s4_rp;
    end
  end

  // stage 6: pressure sums, humidity y*z
  logic signed [63:0] s6_v2, s6_v1b;
  logic signed [17:0] s6_temp;
  logic signed [31:0] s6_x, s6_yz;
  logic [19:0]        s6_rp;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_v2   <= s5_sq6 + (64'(s5_v1p5) <<< 17) + (64'(p4) <<< 35);
      s6_v1b  <= (s5_sq3 >>> 8) + (64'(s5_v1p2) <<< 12);
      s6_temp <= s5_temp;
      s6_x    <= s5_x;
      s6_yz   <= s5_y * s5_z;
      s6_rp   <= s5_rp;
    end
  end

  // stage 7: divisor product, dividend base, humidity times h2
  logic [20:0]        pd_c;
  logic signed [31:0] w1_c;
  logic signed [63:0] s7_d, s7_num;
  logic signed [17:0] s7_temp;
  logic signed [31:0] s7_x, s7_w1h2;

  assign pd_c = 21'(esc_pkg::PRESS_BASE) - {1'b0, s6_rp};
  assign w1_c = (s6_yz >>> 10) + 32'(esc_pkg::HUM_W_BASE);

  always_ff @(posedge clk) begin
    if (en) begin
      s7_d    <= (64'sh0000_8000_0000_0000 + s6_v1b) * $signed(64'(p1));
      s7_num  <= $signed({12'b0, pd_c, 31'b0}) - s6_v2;
      s7_temp <= s6_temp;
      s7_x    <= s6_x;
      s7_w1h2 <= w1_c * 32'(h2);
    end
  end

  // stage 8: divisor, scaled dividend, humidity x*w
  logic signed [31:0] w8_c;
  logic signed [30:0] s8_dv;
  logic signed [63:0] s8_numer;
  logic signed [17:0] s8_temp;
  logic signed [31:0] s8_hw;

  assign w8_c = (s7_w1h2 + 32'(esc_pkg::HUM_H2_ROUND)) >>> 14;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_dv    <= 31'(s7_d >>> 33);
      s8_numer <= s7_num * 64'(esc_pkg::PRESS_SCALE);
      s8_temp  <= s7_temp;
      s8_hw    <= s7_x * w8_c;
    end
  end

  // magnitudes and signs into the divider
  logic [63:0]        an_c;
  logic [30:0]        ad_c;
  logic signed [31:0] s_c;
  side_t              dside_in, dside;
  logic               div_valid;
  logic [63:0]        qmag;
  logic [$bits(side_t)-1:0] dside_bits;

  assign an_c = s8_numer[63] ? (~s8_numer + 64'd1) : s8_numer;
  assign ad_c = s8_dv[30] ? (~s8_dv + 31'd1) : s8_dv;
  assign s_c  = s8_hw >>> 15;

  assign dside_in.neg  = s8_numer[63] ^ s8_dv[30];
  assign dside_in.zero = (s8_dv == 31'sd0);
  assign dside_in.temp = s8_temp;
  assign dside_in.hw   = s8_hw;
  assign dside_in.ss   = s_c * s_c;

  esc_div #(
    .N_W    (esc_pkg::DIV_NUM_W),
    .D_W    (esc_pkg::DIV_DEN_W),
    .SIDE_W ($bits(side_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fv[7]),
    .num       (an_c),
    .den       (ad_c),
    .side      (dside_in),
    .out_valid (div_valid),
    .quo       (qmag),
    .side_out  (dside_bits)
  );

  assign dside = dside_bits;

  // back stage 1: signed quotient, humidity correction product
  logic signed [31:0] ssd_c;
  logic signed [63:0] b1_q;
  logic signed [31:0] b1_hm, b1_hw;
  logic signed [17:0] b1_temp;
  logic               b1_zero;

  assign ssd_c = dside.ss;

  always_ff @(posedge clk) begin
    if (en) begin
      b1_q    <= dside.neg ? (64'sd0 - $signed(qmag)) : $signed(qmag);
      b1_hm   <= (ssd_c >>> 7) * $signed(32'(h1));
      b1_hw   <= dside.hw;
      b1_temp <= dside.temp;
      b1_zero <= dside.zero;
    end
  end

  // back stage 2: humidity clamp, pressure correction products
  logic signed [31:0] hv_c;
  logic [31:0]        hcl_c;
  logic signed [63:0] q13_c;
  logic [16:0]        b2_hum;
  logic signed [63:0] b2_e2m, b2_a9, b2_q13, b2_q;
  logic signed [17:0] b2_temp;
  logic               b2_zero;

  assign hv_c  = b1_hw - (b1_hm >>> 4);
  assign q13_c = b1_q >>> 13;

  // clamp to 0..100 %
  always_comb begin
    if (hv_c[31]) begin
      hcl_c = '0;
    end else if (hv_c > 32'(esc_pkg::HUM_MAX_Q22)) begin
      hcl_c = 32'(esc_pkg::HUM_MAX_Q22);
    end else begin
      hcl_c = hv_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_hum  <= hcl_c[28:12];
      b2_e2m  <= 64'(p8) * b1_q;
      b2_a9   <= 64'(p9) * q13_c;
      b2_q13  <= q13_c;
      b2_q    <= b1_q;
      b2_temp <= b1_temp;
      b2_zero <= b1_zero;
    end
  end

  // back stage 3: low 64 bits of the 64x64 product in 32-bit pieces
  logic [63:0]        b3_m0;
  logic [31:0]        b3_m1, b3_m2;
  logic signed [63:0] b3_e2, b3_q;
  logic [16:0]        b3_hum;
  logic signed [17:0] b3_temp;
  logic               b3_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      b3_m0   <= {32'b0, b2_a9[31:0]} * {32'b0, b2_q13[31:0]};
      b3_m1   <= b2_a9[31:0] * b2_q13[63:32];
      b3_m2   <= b2_a9[63:32] * b2_q13[31:0];
      b3_e2   <= b2_e2m >>> 19;
      b3_q    <= b2_q;
      b3_hum  <= b2_hum;
      b3_temp <= b2_temp;
      b3_zero <= b2_zero;
    end
  end

  // back stage 4: assemble the product
  logic [63:0]        b4_e1p;
  logic signed [63:0] b4_e2, b4_q;
  logic [16:0]        b4_hum;
  logic signed [17:0] b4_temp;
  logic               b4_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      b4_e1p  <= b3_m0 + {b3_m1 + b3_m2, 32'b0};
      b4_e2   <= b3_e2;
      b4_q    <= b3_q;
      b4_hum  <= b3_hum;
      b4_temp <= b3_temp;
      b4_zero <= b3_zero;
    end
  end

  // final stage: pressure sum and result
  logic signed [63:0] e1_c, pt_c;
  esc_pkg::out_t      res_c, fin;

  assign e1_c = $signed(b4_e1p) >>> 25;
  assign pt_c = ((b4_q + e1_c + b4_e2) >>> 8) + (64'(p7) <<< 4);

  always_comb begin
    res_c.temperature_centideg = b4_temp;
    res_c.pressure_pa          = b4_zero ? 24'd0 : pt_c[31:8];
    res_c.pressure_invalid     = b4_zero;
    res_c.humidity_q10         = b4_hum;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin <= res_c;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      fv        <= '0;
      bv        <= '0;
      fin_valid <= 1'b0;
    end else if (en) begin
      fv        <= {fv[6:0], in_valid};
      bv        <= {bv[2:0], div_valid};
      fin_valid <= bv[3];
    end
  end

  // output register and skid entry
  logic          take, move;
  esc_pkg::out_t skid;

  assign take = out_valid && !out_stall;
  assign move = en && fin_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (take) begin
        out_data  <= skid;
        skid_full <= 1'b0;
      end
    end else if (move) begin
      if (!out_valid || take) begin
        out_data  <= fin;
        out_valid <= 1'b1;
      end else begin
        skid      <= fin;
        skid_full <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/core/esc_checker.sv
// ---------------------------------------------------------------------------
// esc_checker
// Port-level checks of the sensor compensation block, bound to the top level.
// ---------------------------------------------------------------------------
`include "env_sensor_compensation_macros.svh"

module esc_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input esc_pkg::out_t out_data
);

  // a stalled result holds
  `ESC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled item changed")

  // humidity never exceeds 100 %
  `ESC_ASSERT_NOW(a_hum_range, out_valid, out_data.humidity_q10 <= 17'd102400, "humidity out of range")

  // an invalid pressure reads as zero
  `ESC_ASSERT_NOW(a_press_zero, out_valid && out_data.pressure_invalid, out_data.pressure_pa == 24'd0, "invalid pressure not zero")

  // input backpressure only follows a blocked output
  `ESC_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall), "stall without blocked output")

  // buffer full implies a result on show
  `ESC_ASSERT_NOW(a_stall_out, in_stall, out_valid, "stall with empty output")

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/tb_env_sensor_compensation.sv
// ---------------------------------------------------------------------------
// tb_env_sensor_compensation
// Self-checking bench for the sensor compensation block. Raw frames are sent
// under several calibration sets: reset (all zero), typical factory values,
// extreme coefficients and random ones. A bit-accurate model of the integer
// compensation predicts each result, and results are checked in order.
// ---------------------------------------------------------------------------
module tb_env_sensor_compensation;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int HOLD_CYCLES    = 400;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [esc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [esc_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  esc_pkg::in_t                    in_data;
  logic                            out_valid;
  logic                            out_stall;
  esc_pkg::out_t                   out_data;

  env_sensor_compensation dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // calibration copy held by the bench
  logic [47:0] cal_temp;
  logic [63:0] cal_press_low;
  logic [63:0] cal_press_high;
  logic [15:0] cal_press_nine;
  logic [63:0] cal_hum;

  esc_pkg::in_t  frames_pending[$];
  esc_pkg::out_t results_expected[$];

  int   tx_idle_pct;
  int   rx_idle_pct;
  bit   hold_request;
  bit   hold_done;
  int   hold_left;
  bit   frame_taken;
  int   mismatches;
  int   frames_sent;
  int   results_seen;
  int   invalid_seen;
  int   quiet_cycles;

  function automatic logic [63:0] sra64(logic [63:0] v, int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [31:0] sra32(logic [31:0] v, int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // integer compensation of one frame under the current calibration
  function automatic esc_pkg::out_t compensate(esc_pkg::in_t f);
    esc_pkg::out_t r;
    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] a, b, tf, v1, v2, pr, num, an, ad, q, qs, e1, e2;
    logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y, z, w, hv, s, rh;
    t1 = {48'd0, cal_temp[15:0]};
    t2 = sx16(cal_temp[31:16]);
    t3 = sx16(cal_temp[47:32]);
    p1 = {48'd0, cal_press_low[15:0]};
    p2 = sx16(cal_press_low[31:16]);
    p3 = sx16(cal_press_low[47:32]);
    p4 = sx16(cal_press_low[63:48]);
    p5 = sx16(cal_press_high[15:0]);
    p6 = sx16(cal_press_high[31:16]);
    p7 = sx16(cal_press_high[47:32]);
    p8 = sx16(cal_press_high[63:48]);
    p9 = sx16(cal_press_nine);
    h1 = {24'd0, cal_hum[7:0]};
    h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
    h3 = {24'd0, cal_hum[31:24]};
    h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
    h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
    h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};

    // temperature and fine temperature
    a  = ({44'd0, f.raw_temperature} >> 3) - (t1 << 1);
    b  = ({44'd0, f.raw_temperature} >> 4) - t1;
    tf = sra64(a * t2, 11) + sra64(sra64(b * b, 12) * t3, 14);
    pr = sra64(tf * 64'd5 + 64'd128, 8);
    r.temperature_centideg = pr[17:0];

    // pressure, 64-bit wrapping datapath
    v1 = tf - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
    r.pressure_pa = '0;
    r.pressure_invalid = 1'b0;
    if (v1 == 64'd0) begin
      r.pressure_invalid = 1'b1;
    end else begin
      pr  = 64'd1048576 - {44'd0, f.raw_pressure};
      num = ((pr << 31) - v2) * 64'd3125;
      an  = num[63] ? -num : num;
      ad  = v1[63] ? -v1 : v1;
      q   = an / ad;
      pr  = (num[63] ^ v1[63]) ? -q : q;
      qs  = sra64(pr, 13);
      e1  = sra64(p9 * qs * qs, 25);
      e2  = sra64(p8 * pr, 19);
      pr  = sra64(pr + e1 + e2, 8) + (p7 << 4);
      r.pressure_pa = pr[31:8];
    end

    // humidity, 32-bit wrapping datapath with clamp
    rh = {16'd0, f.raw_humidity};
    v  = tf[31:0] - 32'd76800;
    x  = (rh << 14) - (h4 << 20) - h5 * v + 32'd16384;
    x  = sra32(x, 15);
    y  = sra32(v * h6, 10);
    z  = sra32(v * h3, 11) + 32'd32768;
    w  = sra32(y * z, 10) + 32'd2097152;
    w  = sra32(w * h2 + 32'd8192, 14);
    hv = x * w;
    s  = sra32(hv, 15);
    hv = hv - sra32(sra32(s * s, 7) * h1, 4);
    if (hv[31]) hv = '0;
    if (hv > 32'd419430400) hv = 32'd419430400;
    r.humidity_q10 = hv[28:12];
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // accept side: predict on every accepted frame
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      results_expected.push_back(compensate(in_data));
      frame_taken = 1'b1;
      frames_sent++;
    end
  end

  // frame driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || frame_taken) begin
      frame_taken = 1'b0;
      if (frames_pending.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_data  <= frames_pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_request && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    esc_pkg::out_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (results_expected.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        mismatches++;
      end else begin
        exp_r = results_expected.pop_front();
        if (out_data.pressure_invalid) invalid_seen++;
        if (out_data.temperature_centideg !== exp_r.temperature_centideg) begin
          $error("temperature_centideg exp %0d got %0d",
                 exp_r.temperature_centideg, out_data.temperature_centideg);
          mismatches++;
        end
        if (out_data.pressure_pa !== exp_r.pressure_pa) begin
          $error("pressure_pa exp %0d got %0d", exp_r.pressure_pa, out_data.pressure_pa);
          mismatches++;
        end
        if (out_data.pressure_invalid !== exp_r.pressure_invalid) begin
          $error("pressure_invalid exp %0b got %0b",
                 exp_r.pressure_invalid, out_data.pressure_invalid);
          mismatches++;
        end
        if (out_data.humidity_q10 !== exp_r.humidity_q10) begin
          $error("humidity_q10 exp %0d got %0d", exp_r.humidity_q10, out_data.humidity_q10);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [esc_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // load a full calibration set into the block and the bench copy
  task automatic load_cal(logic [47:0] tc, logic [63:0] pl, logic [63:0] ph,
                          logic [15:0] p9, logic [63:0] hc);
    cal_temp = tc;
    cal_press_low = pl;
    cal_press_high = ph;
    cal_press_nine = p9;
    cal_hum = hc;
    write_reg(esc_pkg::REG_TEMP_CAL, {16'd0, tc});
    write_reg(esc_pkg::REG_PRESS_CAL_LOW, pl);
    write_reg(esc_pkg::REG_PRESS_CAL_HIGH, ph);
    write_reg(esc_pkg::REG_PRESS_CAL_NINE, {48'd0, p9});
    write_reg(esc_pkg::REG_HUM_CAL, hc);
  endtask

  task automatic wait_drained();
    wait (frames_pending.size() == 0 && !in_valid && results_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic esc_pkg::in_t make_frame(int unsigned rt, int unsigned rp,
                                              int unsigned rh);
    esc_pkg::in_t f;
    f.raw_temperature = rt[19:0];
    f.raw_pressure    = rp[19:0];
    f.raw_humidity    = rh[15:0];
    return f;
  endfunction

  // mostly plausible readings, some anywhere in range
  task automatic queue_random_frames(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        frames_pending.push_back(make_frame($urandom, $urandom, $urandom));
      else
        frames_pending.push_back(make_frame($urandom_range(600000, 380000),
                                            $urandom_range(560000, 200000),
                                            $urandom_range(50000, 15000)));
    end
  endtask

  task automatic queue_directed_frames();
    frames_pending.push_back(make_frame(0, 0, 0));
    frames_pending.push_back(make_frame('hFFFFF, 'hFFFFF, 'hFFFF));
    frames_pending.push_back(make_frame(0, 'hFFFFF, 0));
    frames_pending.push_back(make_frame('hFFFFF, 0, 'hFFFF));
    frames_pending.push_back(make_frame('h55555, 'hAAAAA, 'h5555));
    frames_pending.push_back(make_frame('hAAAAA, 'h55555, 'hAAAA));
    frames_pending.push_back(make_frame(519888, 415148, 30000));
    frames_pending.push_back(make_frame(519888, 415148, 0));
    frames_pending.push_back(make_frame(519888, 415148, 'hFFFF));
  endtask

  logic [63:0] typ_tc, typ_pl, typ_ph, typ_hc;

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = esc_pkg::REG_TEMP_CAL;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    hold_request = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    frame_taken = 1'b0;
    mismatches = 0;
    frames_sent = 0;
    results_seen = 0;
    invalid_seen = 0;
    quiet_cycles = 0;
    cal_temp = '0;
    cal_press_low = '0;
    cal_press_high = '0;
    cal_press_nine = '0;
    cal_hum = '0;
    tx_idle_pct = 31;
    rx_idle_pct = 84;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // typical factory calibration
    typ_tc = {16'd0, -16'sd1000, 16'd26435, 16'd27504};
    typ_pl = {16'd2855, 16'd3024, -16'sd10685, 16'd36477};
    typ_ph = {-16'sd14600, 16'd15500, -16'sd7, 16'd140};
    typ_hc = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

    // reset calibration: divisor zero, pressure flagged
    queue_directed_frames();
    queue_random_frames(20);
    wait_drained();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        tx_idle_pct = 84;
        rx_idle_pct = 31;
      end else if (ph == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (ph)
        0, 3, 6: load_cal(typ_tc[47:0], typ_pl, typ_ph, 16'd6000, typ_hc);
        1: load_cal({48{1'b1}}, {64{1'b1}}, {64{1'b1}}, 16'hFFFF, {64{1'b1}});
        2: load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000,
                    16'hFFFF}, {4{16'h8000}}, 16'h8000, {8'h80, 12'h800, 12'h800,
                    8'hFF, 16'h8000, 8'hFF});
        4: load_cal({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h7FFF, 16'h7FFF, 16'h7FFF,
                    16'h0000}, {4{16'h7FFF}}, 16'h7FFF, {8'h7F, 12'h7FF, 12'h7FF,
                    8'h00, 16'h7FFF, 8'h00});
        default: load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                          {$urandom, $urandom}, 16'($urandom), {$urandom, $urandom});
      endcase
      if (ph < 3) queue_directed_frames();
      if (ph == 6) begin
        queue_random_frames(100);
        hold_request = 1'b1;
      end
      queue_random_frames(100);
      wait_drained();
    end

    $display("covered %0d frames over 10 calibration sets, %0d results, %0d flagged pressure",
             frames_sent, results_seen, invalid_seen);
    $display("idle mixes 31/84, 84/31 and none, plus a %0d-cycle receiver hold-off",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/esc_pkg.sv
rtl/core/esc_div.sv
rtl/core/env_sensor_compensation.sv
rtl/core/esc_checker.sv
tb/tb_env_sensor_compensation.sv
